/* rtl/core/sorted_free_list_best_fit_macros.svh */
// ----------------------------------------------------------------------------
// sorted free list assertion macros
// clocked implication helpers shared by the checker
// ----------------------------------------------------------------------------
`ifndef SORTED_FREE_LIST_BEST_FIT_MACROS_SVH
`define SORTED_FREE_LIST_BEST_FIT_MACROS_SVH

// same-cycle implication
`define SFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sfl_pkg.sv */
// ----------------------------------------------------------------------------
// sfl_pkg
// shared types and codes of the sorted best-fit free list
// ----------------------------------------------------------------------------
package sfl_pkg;

  localparam int ENTRIES_DEF   = 16;
  localparam int SIZE_BITS_DEF = 16;
  localparam int POS_BITS_DEF  = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_ALLOC  = 1'b1;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [15:0] slot_size;
    logic [31:0] slot_position;
  } sfl_in_t;

  typedef struct packed {
    logic [31:0] found_position;
    logic [1:0]  status;
  } sfl_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } sfl_state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    logic alloc;
    logic hit;
  } sfl_cell_ctrl_t;

endpackage

/* rtl/core/sfl_cell.sv */
// ----------------------------------------------------------------------------
// sfl_cell
// one slot of the sorted row: compares against the request and shifts
// ----------------------------------------------------------------------------
module sfl_cell #(
  parameter int SIZE_BITS = 16,
  parameter int POS_BITS  = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sfl_pkg::sfl_cell_ctrl_t ctrl,
  input  logic [SIZE_BITS-1:0]   key,
  input  logic [POS_BITS-1:0]    new_pos,
  input  logic                   left_valid,
  input  logic [SIZE_BITS-1:0]   left_size,
  input  logic [POS_BITS-1:0]    left_pos,
  input  logic                   left_flag,
  input  logic                   right_valid,
  input  logic [SIZE_BITS-1:0]   right_size,
  input  logic [POS_BITS-1:0]    right_pos,
  output logic                   valid_o,
  output logic [SIZE_BITS-1:0]   size_o,
  output logic [POS_BITS-1:0]    pos_o,
  output logic                   flag_o,
  output logic [POS_BITS-1:0]    sel_pos_o
);
  import sfl_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  logic                 flag_r, flag_nxt;
  logic                 first;

  // flags rise at most once along the row, so the first hit is local
  assign first = flag_r & ~left_flag;

  always_comb begin
    valid_nxt = valid_r;
    size_nxt  = size_r;
    pos_nxt   = pos_r;
    flag_nxt  = flag_r;
    if (ctrl.cmp_en) begin
      if (ctrl.alloc) begin
        flag_nxt = valid_r & (size_r >= key);
      end else begin
        // empty cells count as larger so the first free cell takes the slot
        flag_nxt = ~valid_r | (size_r > key);
      end
    end
    if (ctrl.upd_en && ctrl.hit) begin
      if (ctrl.alloc) begin
        if (flag_r || !valid_r) begin
          valid_nxt = right_valid;
          size_nxt  = right_size;
          pos_nxt   = right_pos;
        end
      end else if (first) begin
        valid_nxt = 1'b1;
        size_nxt  = key;
        pos_nxt   = new_pos;
      end else if (left_flag) begin
        valid_nxt = left_valid;
        size_nxt  = left_size;
        pos_nxt   = left_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      flag_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      flag_r  <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r <= size_nxt;
    pos_r  <= pos_nxt;
  end

  assign valid_o   = valid_r;
  assign size_o    = size_r;
  assign pos_o     = pos_r;
  assign flag_o    = flag_r;
  assign sel_pos_o = first ? pos_r : '0;

endmodule

/* rtl/core/sorted_free_list_best_fit.sv */
// ----------------------------------------------------------------------------
// sorted_free_list_best_fit
// best-fit free slot table kept as a sorted row of cells
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one request per item, cmd 0 frees a slot (size, position),
//           cmd 1 allocates the smallest slot of at least slot_size
//   out_* : one result per request, found_position and status
//           (ok, no fit, table full)
//   timing: a request is taken into the request register, then every cell
//   runs a compare step against it, then a shift step along the row also
//   loads the result register; in_stall stays high until that shift, so the
//   block takes no new request before it is through with the last one
//   equal sizes keep arrival order; an insert into a full table is dropped
//   reset empties the table at once, no sweep is needed
//   while out_stall holds a result, the shift cycle of the next request
//   waits, and in_stall stays high until the table has moved on
// ----------------------------------------------------------------------------
module sorted_free_list_best_fit #(
  parameter int ENTRIES   = sfl_pkg::ENTRIES_DEF,
  parameter int SIZE_BITS = sfl_pkg::SIZE_BITS_DEF,
  parameter int POS_BITS  = sfl_pkg::POS_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sfl_pkg::sfl_in_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output sfl_pkg::sfl_out_t out_data
);
  import sfl_pkg::*;

  sfl_state_t state_r, state_nxt;

  logic                 cmd_r;
  logic [SIZE_BITS-1:0] key_r;
  logic [POS_BITS-1:0]  pos_r;
  logic                 out_valid_r, out_valid_nxt;
  sfl_out_t             out_data_r;

  logic [SIZE_BITS+15:0] key_wide;
  logic [POS_BITS+31:0]  pos_wide;
  logic [POS_BITS+31:0]  found_wide;

  logic                 cv   [ENTRIES];
  logic [SIZE_BITS-1:0] csz  [ENTRIES];
  logic [POS_BITS-1:0]  cpos [ENTRIES];
  logic                 cflag[ENTRIES];
  logic [POS_BITS-1:0]  csel [ENTRIES];

  logic                 accept;
  logic                 load_out;
  logic                 any_fit;
  logic                 full;
  logic [POS_BITS-1:0]  found;
  sfl_cell_ctrl_t       ctrl;

  assign accept   = in_valid & ~in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign key_wide = {{SIZE_BITS{1'b0}}, in_data.slot_size};
  assign pos_wide = {{POS_BITS{1'b0}}, in_data.slot_position};
  assign full     = cv[ENTRIES-1];

  always_comb begin
    any_fit = 1'b0;
    found   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      any_fit = any_fit | cflag[i];
      found   = found | csel[i];
    end
  end

  assign found_wide = {32'd0, found};

  always_comb begin
    state_nxt   = state_r;
    load_out    = 1'b0;
    ctrl.cmp_en = 1'b0;
    ctrl.upd_en = 1'b0;
    ctrl.alloc  = (cmd_r == CMD_ALLOC);
    ctrl.hit    = (cmd_r == CMD_ALLOC) ? any_fit : ~full;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        if (!out_valid_r || !out_stall) begin
          ctrl.upd_en = 1'b1;
          load_out    = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data.cmd;
      key_r <= key_wide[SIZE_BITS-1:0];
      pos_r <= pos_wide[POS_BITS-1:0];
    end
    if (load_out) begin
      if (cmd_r == CMD_ALLOC) begin
        out_data_r.found_position <= any_fit ? found_wide[31:0] : 32'd0;
        out_data_r.status         <= any_fit ? STATUS_OK : STATUS_NO_FIT;
      end else begin
        out_data_r.found_position <= 32'd0;
        out_data_r.status         <= full ? STATUS_FULL : STATUS_OK;
      end
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic                 lv, lf, rv;
    logic [SIZE_BITS-1:0] ls, rs;
    logic [POS_BITS-1:0]  lp, rp;

    if (i == 0) begin : g_head
      assign lv = 1'b0;
      assign lf = 1'b0;
      assign ls = '0;
      assign lp = '0;
    end else begin : g_body
      assign lv = cv[i-1];
      assign lf = cflag[i-1];
      assign ls = csz[i-1];
      assign lp = cpos[i-1];
    end

    if (i == ENTRIES - 1) begin : g_tail
      assign rv = 1'b0;
      assign rs = '0;
      assign rp = '0;
    end else begin : g_mid
      assign rv = cv[i+1];
      assign rs = csz[i+1];
      assign rp = cpos[i+1];
    end

    sfl_cell #(
      .SIZE_BITS(SIZE_BITS),
      .POS_BITS (POS_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .key        (key_r),
      .new_pos    (pos_r),
      .left_valid (lv),
      .left_size  (ls),
      .left_pos   (lp),
      .left_flag  (lf),
      .right_valid(rv),
      .right_size (rs),
      .right_pos  (rp),
      .valid_o    (cv[i]),
      .size_o     (csz[i]),
      .pos_o      (cpos[i]),
      .flag_o     (cflag[i]),
      .sel_pos_o  (csel[i])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/sfl_checker.sv */
// ----------------------------------------------------------------------------
// sfl_checker
// port-level checks of the sorted free list, bound to the top level
// ----------------------------------------------------------------------------
`include "sorted_free_list_best_fit_macros.svh"

module sfl_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input sfl_pkg::sfl_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input sfl_pkg::sfl_out_t out_data
);
  import sfl_pkg::*;

  logic in_acc;
  logic out_held;
  logic res_fail;

  assign in_acc   = in_valid & ~in_stall;
  assign out_held = out_valid & out_stall;
  assign res_fail = out_valid && (out_data.status != STATUS_OK);

  // one request at a time: the block is busy right after taking one
  `SFL_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_acc, in_stall, "request taken while busy")

  `SFL_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, out_data.status <= STATUS_FULL, "bad status code")

  // every failed result reports a zero position; inserts always report zero
  `SFL_ASSERT_IMP(a_pos_zero, clk, rst_n, res_fail, out_data.found_position == 32'd0, "bad position")

  `SFL_ASSERT_NXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(out_data), "result moved")

endmodule

bind sorted_free_list_best_fit sfl_checker u_sfl_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

/* verif/sfl_best_fit_checker.sv */
// ----------------------------------------------------------------------------
// sfl_best_fit_checker
// watches both channels of the best-fit free list, predicts every result
// from its own sorted table and compares field by field, oldest first
// ----------------------------------------------------------------------------
module sfl_best_fit_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  sfl_pkg::sfl_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  sfl_pkg::sfl_out_t out_data,
  output int                mismatches,
  output int                pending
);
  import sfl_pkg::*;

  localparam int SLOTS = ENTRIES_DEF;

  logic [15:0] free_size [SLOTS];
  logic [31:0] free_pos  [SLOTS];
  int          free_count = 0;
  sfl_out_t    expected_results [$];
  sfl_out_t    want;
  int          errors = 0;

  // sorted insert after equal sizes, first-fit from the small end on allocate
  task automatic best_fit_step(input sfl_in_t req, output sfl_out_t res);
    int at;
    int k;
    res.found_position = '0;
    res.status         = STATUS_OK;
    at = 0;
    if (req.cmd == CMD_INSERT) begin
      if (free_count == SLOTS) begin
        res.status = STATUS_FULL;
      end else begin
        while (at < free_count && free_size[at] <= req.slot_size) at++;
        for (k = free_count; k > at; k--) begin
          free_size[k] = free_size[k-1];
          free_pos[k]  = free_pos[k-1];
        end
        free_size[at] = req.slot_size;
        free_pos[at]  = req.slot_position;
        free_count++;
      end
    end else begin
      while (at < free_count && free_size[at] < req.slot_size) at++;
      if (at == free_count) begin
        res.status = STATUS_NO_FIT;
      end else begin
        res.found_position = free_pos[at];
        for (k = at; k + 1 < free_count; k++) begin
          free_size[k] = free_size[k+1];
          free_pos[k]  = free_pos[k+1];
        end
        free_count--;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got position %h status %0d",
                   $time, out_data.found_position, out_data.status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.found_position !== want.found_position) begin
            $display("%0t: found_position mismatch, expected %h got %h",
                     $time, want.found_position, out_data.found_position);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d got %0d",
                     $time, want.status, out_data.status);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        best_fit_step(in_data, want);
        expected_results.push_back(want);
      end
    end
    mismatches <= errors;
    pending    <= expected_results.size();
  end

endmodule

/* verif/tb_sorted_free_list_best_fit.sv */
// ----------------------------------------------------------------------------
// tb_sorted_free_list_best_fit
// drives insert and allocate requests into the best-fit free list: a short
// directed pass over empty, full, tie and size-extreme cases, then random
// fill/drain phases with random idling on both channels
// ----------------------------------------------------------------------------
module tb_sorted_free_list_best_fit;
  import sfl_pkg::*;

  localparam int RANDOM_ITEMS = 1650;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 12;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  sfl_in_t   in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  sfl_out_t  out_data;
  logic      quiet_run = 1'b0;
  int        mismatch_count;
  int        pending_results;
  int        cycle_count = 0;
  int        phase_left  = 0;
  int        insert_pct  = 50;

  sorted_free_list_best_fit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sfl_best_fit_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatch_count),
    .pending    (pending_results)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !quiet_run && ($urandom_range(99) < 31);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_free_list_best_fit test failed");
      $finish;
    end
  end

  // mostly small sizes so ties and exact fits are common
  function automatic logic [15:0] pick_size();
    logic [15:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = 16'($urandom_range(15));
      5:             v = 16'hFFFF - 16'($urandom_range(2));
      6:             v = 16'($urandom_range(2));
      default:       v = 16'($urandom);
    endcase
    return v;
  endfunction

  // valid stays up from one request to the next unless an idle cycle is drawn
  task automatic send_request(input logic cmd, input logic [15:0] size,
                              input logic [31:0] pos);
    sfl_in_t req;
    req.cmd           = cmd;
    req.slot_size     = size;
    req.slot_position = pos;
    while (!quiet_run && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, size extremes, exact max fit, no fit
    send_request(CMD_ALLOC, 16'h0000, $urandom);
    send_request(CMD_INSERT, 16'h0000, 32'h0000_0000);
    send_request(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(CMD_ALLOC, 16'hFFFF, 32'h0000_0000);
    send_request(CMD_ALLOC, 16'h0001, 32'hFFFF_FFFF);
    send_request(CMD_ALLOC, 16'h0000, $urandom);
    // fill to the top with pairs of equal sizes, then one more insert
    for (int k = 0; k < ENTRIES_DEF; k++) begin
      send_request(CMD_INSERT, (k == ENTRIES_DEF - 1) ? 16'hFFFF : 16'((k >> 1) * 16'h1111),
                   $urandom);
    end
    send_request(CMD_INSERT, 16'h2000, $urandom);
    send_request(CMD_ALLOC, 16'h1112, $urandom);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(80, 20);
        case ($urandom_range(2))
          0:       insert_pct = 80;
          1:       insert_pct = 50;
          default: insert_pct = 25;
        endcase
      end
      phase_left--;
      if (n == 400) quiet_run <= 1'b1;
      if (n == 700) quiet_run <= 1'b0;
      if (n == 900) wait_for_results();
      if ($urandom_range(99) < insert_pct) begin
        send_request(CMD_INSERT, pick_size(), $urandom);
      end else begin
        send_request(CMD_ALLOC, pick_size(), $urandom);
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("sorted_free_list_best_fit test passed");
    end else begin
      $display("sorted_free_list_best_fit test failed");
    end
    $finish;
  end

endmodule
